// ===== rtl/odhs_pkg.sv =====
// shared types and constants for the ordered double-hash set
// no dependencies; compiled first
package odhs_pkg;

    localparam int SLOTS_DEF    = 256;
    localparam int KEY_BITS_DEF = 32;
    localparam int HOME_SHIFT   = 8;
    localparam int STEP_SHIFT   = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2,
        ST_READ     = 2'd3
    } status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    step_probe;
        logic    load_cur;
        logic    wr_k;
        logic    wr_cur;
        logic    dec_free;
        logic    clr_wr;
        logic    out_load;
        status_t out_status;
    } dp_ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic eq_k;
        logic lt_k;
        logic lt_cur;
        logic rd_zero;
        logic free_zero;
        logic clr_last;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/odhs_req_if.sv =====
// request channel: command, key and slot index with valid/ready
// no dependencies
interface odhs_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] key;
    logic [7:0]  slot_index;

    modport source (output valid, output cmd, output key, output slot_index, input ready);
    modport sink   (input valid, input cmd, input key, input slot_index, output ready);
endinterface

// ===== rtl/odhs_rsp_if.sv =====
// response channel: status and slot key with valid/ready
// depends on odhs_pkg
interface odhs_rsp_if;
    import odhs_pkg::*;
    logic        valid;
    logic        ready;
    status_t     status;
    logic [31:0] slot_key;

    modport source (output valid, output status, output slot_key, input ready);
    modport sink   (input valid, input status, input slot_key, output ready);
endinterface

// ===== rtl/odhs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module odhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/odhs_dp.sv =====
// datapath: slot memory, probe position and step, key registers,
// free count, clear counter and response register; uses odhs_pkg, odhs_ram
module odhs_dp #(
    parameter int SLOTS    = odhs_pkg::SLOTS_DEF,
    parameter int KEY_BITS = odhs_pkg::KEY_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  odhs_pkg::dp_ctl_t ctl,
    output odhs_pkg::dp_sts_t sts,
    input  logic              req_cmd,
    input  logic [31:0]       req_key,
    input  logic [7:0]        req_slot_index,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output odhs_pkg::status_t rsp_status,
    output logic [31:0]       rsp_slot_key
);
    import odhs_pkg::*;

    localparam int AW = $clog2(SLOTS);

    logic [KEY_BITS-1:0] k_reg, cur_reg;
    logic [AW-1:0]       pos_reg, inc_reg, free_reg, clr_reg;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [31:0]         out_key_reg;

    logic [KEY_BITS-1:0]    rdata, key_in, sh_home, sh_step, sh_rstep, wdata;
    logic [KEY_BITS+31:0]   key_ext;
    logic [KEY_BITS+31:0]   rd_ext;
    logic [AW+7:0]          idx_ext;
    logic [AW-1:0]          home, step, rstep, idx, raddr, waddr;
    logic                   we;

    // key masked to KEY_BITS, slot index wrapped to the table
    assign key_ext  = {{KEY_BITS{1'b0}}, req_key};
    assign key_in   = key_ext[KEY_BITS-1:0];
    assign idx_ext  = {{AW{1'b0}}, req_slot_index};
    assign idx      = idx_ext[AW-1:0];
    assign rd_ext   = {32'b0, rdata};

    assign sh_home  = key_in >> HOME_SHIFT;
    assign sh_step  = key_in >> STEP_SHIFT;
    assign sh_rstep = rdata >> STEP_SHIFT;
    assign home     = sh_home[AW-1:0];
    assign step     = sh_step[AW-1:0] | AW'(1);
    assign rstep    = sh_rstep[AW-1:0] | AW'(1);

    always_comb
    begin
        if (ctl.load_in)
        begin
            raddr = (req_cmd == CMD_READ) ? idx : home;
        end
        else if (ctl.step_probe)
        begin
            raddr = AW'(pos_reg + inc_reg);
        end
        else if (ctl.load_cur)
        begin
            raddr = AW'(pos_reg + rstep);
        end
        else
        begin
            raddr = pos_reg;
        end
    end

    assign we    = ctl.wr_k | ctl.wr_cur | ctl.clr_wr;
    assign waddr = ctl.clr_wr ? clr_reg : pos_reg;
    always_comb
    begin
        if (ctl.clr_wr)
        begin
            wdata = '0;
        end
        else if (ctl.wr_k)
        begin
            wdata = k_reg;
        end
        else
        begin
            wdata = cur_reg;
        end
    end

    odhs_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // probe registers and response payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            k_reg   <= key_in;
            pos_reg <= raddr;
            inc_reg <= step;
        end
        else if (ctl.step_probe)
        begin
            pos_reg <= raddr;
        end
        else if (ctl.load_cur)
        begin
            cur_reg <= rdata;
            inc_reg <= rstep;
            pos_reg <= raddr;
        end
        if (ctl.out_load)
        begin
            out_status_reg <= ctl.out_status;
            out_key_reg    <= (ctl.out_status == ST_READ) ? rd_ext[31:0] : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg      <= AW'(SLOTS - 1);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.dec_free)
            begin
                free_reg <= free_reg - AW'(1);
            end
            if (ctl.clr_wr)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.eq_k      = (rdata == k_reg);
    assign sts.lt_k      = (rdata < k_reg);
    assign sts.lt_cur    = (rdata < cur_reg);
    assign sts.rd_zero   = (rdata == '0);
    assign sts.free_zero = (free_reg == '0);
    assign sts.clr_last  = (clr_reg == AW'(SLOTS - 1));
    assign sts.out_free  = !out_valid_reg || rsp_ready;

    assign rsp_valid    = out_valid_reg;
    assign rsp_status   = out_status_reg;
    assign rsp_slot_key = out_key_reg;
endmodule

// ===== rtl/odhs_ctrl.sv =====
// controller: clear sweep, accept, slot read, probe walk and push chain
// depends on odhs_pkg
module odhs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_cmd,
    output logic              req_ready,
    input  odhs_pkg::dp_sts_t sts,
    output odhs_pkg::dp_ctl_t ctl
);
    import odhs_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RDW   = 5'b00100,
        S_PROBE = 5'b01000,
        S_PUSH  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = (req_cmd == CMD_READ) ? S_RDW : S_PROBE;
                end
            end
            S_RDW:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load   = 1'b1;
                    ctl.out_status = ST_READ;
                    state_next     = S_IDLE;
                end
            end
            S_PROBE:
            begin
                if (sts.out_free)
                begin
                    if (sts.eq_k)
                    begin
                        ctl.out_load   = 1'b1;
                        ctl.out_status = ST_PRESENT;
                        state_next     = S_IDLE;
                    end
                    else if (sts.lt_k)
                    begin
                        if (sts.free_zero)
                        begin
                            ctl.out_load   = 1'b1;
                            ctl.out_status = ST_FULL;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            ctl.wr_k     = 1'b1;
                            ctl.dec_free = 1'b1;
                            if (sts.rd_zero)
                            begin
                                ctl.out_load   = 1'b1;
                                ctl.out_status = ST_INSERTED;
                                state_next     = S_IDLE;
                            end
                            else
                            begin
                                ctl.load_cur = 1'b1;
                                state_next   = S_PUSH;
                            end
                        end
                    end
                    else
                    begin
                        ctl.step_probe = 1'b1;
                    end
                end
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    if (sts.lt_cur)
                    begin
                        ctl.wr_cur = 1'b1;
                        if (sts.rd_zero)
                        begin
                            ctl.out_load   = 1'b1;
                            ctl.out_status = ST_INSERTED;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            ctl.load_cur = 1'b1;
                        end
                    end
                    else
                    begin
                        ctl.step_probe = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end
endmodule

// ===== rtl/ordered_double_hash_set.sv =====
// Ordered double-hash set of nonzero keys in one slot memory of SLOTS entries.
// A key's home slot is bits above 8 of the key and its probe step is bits above
// 16 forced odd; along every probe chain keys sit in descending order. After
// reset the block sweeps every slot of the memory to zero and takes no request
// meanwhile. A read request reads the indexed slot and loads it into the
// response register. An insert visits slots first along the new key's chain and
// then along each displaced key's chain until an empty slot is filled; the
// single read port of the slot memory sets this, one slot per cycle while the
// response side does not stall, so a sparse table answers sooner than a crowded
// one. One request is worked at a time; a finished response waits in an output
// register while the next request is accepted, and the next request's work
// pauses while that earlier response still waits unaccepted. One slot is always
// left empty, so an insert of a new key into a table with SLOTS-1 keys answers
// table full.
// depends on odhs_pkg, odhs_req_if, odhs_rsp_if, odhs_ctrl, odhs_dp
module ordered_double_hash_set #(
    parameter int SLOTS    = odhs_pkg::SLOTS_DEF,
    parameter int KEY_BITS = odhs_pkg::KEY_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    odhs_req_if.sink   req,
    odhs_rsp_if.source rsp
);
    import odhs_pkg::*;

    // command and status bundles between controller and datapath
    dp_ctl_t ctl;
    dp_sts_t sts;

    // controller owns the request handshake and the walk sequence
    odhs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // datapath holds the slot memory and the response register
    odhs_dp #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .req_cmd        (req.cmd),
        .req_key        (req.key),
        .req_slot_index (req.slot_index),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_status     (rsp.status),
        .rsp_slot_key   (rsp.slot_key)
    );
endmodule

// ===== rtl/odhs_checker.sv =====
// port-level assertions for the ordered double-hash set
// depends on odhs_pkg; bound to ordered_double_hash_set
module odhs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_slot_key
);
    import odhs_pkg::*;

    // a stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot_key))
        else $error("response changed while stalled");

    // only read responses carry a key
    a_key_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_READ) |-> rsp_slot_key == 32'd0)
        else $error("insert response carries a key");

    // one request at a time: ready drops after each accepted request
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge clk)
        !rst_n |=> !req_ready)
        else $error("request taken during clearing pass");
endmodule

bind ordered_double_hash_set odhs_checker u_odhs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_slot_key (rsp.slot_key)
);
